// ===== hdl/ping_pong_trace_buffer_control_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ping-pong trace buffer control unit
// Concurrent checks clocked on clk; the first form is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PING_PONG_TRACE_BUFFER_CONTROL_UNIT_ASSERT_SVH
`define PING_PONG_TRACE_BUFFER_CONTROL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PPTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PPTB_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPTB_ASSERT(lbl, prop, msg)
`define PPTB_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

// ===== hdl/pptb_pkg.sv =====
// ----------------------------------------------------------------------------
// pptb_pkg
// Beat types and codes for the ping-pong trace buffer control unit.
// ----------------------------------------------------------------------------
package pptb_pkg;

    // operation codes
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_STOP   = 3'd1;
    localparam logic [2:0] OP_RESET  = 3'd2;
    localparam logic [2:0] OP_EVENT  = 3'd3;
    localparam logic [2:0] OP_SUSP   = 3'd4;
    localparam logic [2:0] OP_RESUME = 3'd5;
    localparam logic [2:0] OP_GUEST  = 3'd6;
    localparam logic [2:0] OP_DUMP   = 3'd7;

    // stop reasons
    localparam logic [1:0] REASON_NONE      = 2'd0;
    localparam logic [1:0] REASON_HW        = 2'd1;
    localparam logic [1:0] REASON_EXHAUSTED = 2'd2;

    // operation status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSUPP  = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_NO_DATA = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic        status_pending;
        logic        error_class_set;
        logic        full_service;
        logic        loss_flag;
        logic [31:0] write_offset;
        logic [63:0] epoch;
    } in_beat_t;

    typedef struct packed {
        logic        is_running;
        logic [1:0]  sealed_halves;
        logic        current_half;
        logic [1:0]  stop_reason;
        logic [1:0]  op_status;
        logic [31:0] full_events;
        logic [31:0] error_events;
        logic [31:0] loss_events;
        logic [15:0] half0_fill;
        logic [15:0] half1_fill;
        logic        dump_half;
        logic [15:0] dump_length;
    } out_beat_t;

endpackage

// ===== hdl/ping_pong_trace_buffer_control_unit.sv =====
// ----------------------------------------------------------------------------
// ping_pong_trace_buffer_control_unit
// Control of a two-half sampling buffer: start/stop, buffer-full sealing,
// suspend/resume, error counting and dump queries.
// ----------------------------------------------------------------------------
// Path: an accepted input beat reaches its result beat through the input
//   register, then the single-pass update into the result register.
// Throughput: one beat per cycle while the result channel is not stalled.
// Reset: rst_n asynchronous, active low; clears all control state, counters,
//   fills and the availability register. No clearing pass is needed.
`include "ping_pong_trace_buffer_control_unit_assert.svh"

module ping_pong_trace_buffer_control_unit #(
    parameter int BUFFER_BYTES   = 65536,
    parameter int DUMP_MAX_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration: unit_available
    input  logic                cfg_we,
    input  logic                cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  pptb_pkg::in_beat_t  in_data,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output pptb_pkg::out_beat_t out_data
);

    // Half size and dump limit, held wide enough for the offset compare.
    localparam logic [32:0] HALF     = 33'(BUFFER_BYTES / 2);
    localparam logic [31:0] DUMP_MAX = 32'(DUMP_MAX_BYTES);

    // ------------------------------------------------------------------
    // Pipeline control. Stage 1 holds the accepted beat, stage 2 the
    // result. Stage 1 moves on whenever the result register is free or
    // is being drained this cycle, so a waiting result does not block
    // a new beat from being captured once stage 1 has moved.
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    pptb_pkg::in_beat_t  s1_data_reg;
    logic                out_valid_reg;
    pptb_pkg::out_beat_t out_data_reg;

    logic s2_load;
    logic s1_fire;
    logic in_take;

    assign s2_load  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s2_load;
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic        avail_reg;
    logic        running_reg,  running_next;
    logic [1:0]  ready_reg,    ready_next;
    logic        active_reg,   active_next;
    logic [1:0]  reason_reg,   reason_next;
    logic [15:0] fill0_reg,    fill0_next;
    logic [15:0] fill1_reg,    fill1_next;
    logic [31:0] full_cnt_reg, full_cnt_next;
    logic [31:0] err_cnt_reg,  err_cnt_next;
    logic [31:0] loss_cnt_reg, loss_cnt_next;
    logic        resume_reg,   resume_next;
    logic [63:0] epoch_reg,    epoch_next;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // ------------------------------------------------------------------
    // Single-pass update
    // ------------------------------------------------------------------
    logic [1:0]  status;
    logic        dump_half;
    logic [15:0] dump_len;
    logic [1:0]  start_status;
    logic        start_go;
    logic [32:0] off_ext;
    logic [32:0] base;
    logic [32:0] used;
    logic        off_ok;
    logic [15:0] used_sat;
    logic [15:0] sel_fill;
    logic        other_sealed;

    // start: not supported when unavailable, ok when already running,
    // busy while any half is still sealed
    always_comb
    begin
        start_go = avail_reg && !running_reg && (ready_reg == 2'b00);
        if (!avail_reg)
            start_status = pptb_pkg::ST_NOSUPP;
        else if (running_reg)
            start_status = pptb_pkg::ST_OK;
        else if (ready_reg != 2'b00)
            start_status = pptb_pkg::ST_BUSY;
        else
            start_status = pptb_pkg::ST_OK;
    end

    // offset window of the active half, upper bound inclusive
    assign off_ext      = {1'b0, s1_data_reg.write_offset};
    assign base         = active_reg ? HALF : 33'd0;
    assign off_ok       = (off_ext >= base) && (off_ext <= base + HALF);
    assign used         = off_ext - base;
    assign used_sat     = (|used[32:16]) ? 16'hFFFF : used[15:0];
    assign other_sealed = active_reg ? ready_reg[0] : ready_reg[1];
    assign sel_fill     = ready_reg[1] ? fill1_reg : fill0_reg;

    always_comb
    begin
        running_next  = running_reg;
        ready_next    = ready_reg;
        active_next   = active_reg;
        reason_next   = reason_reg;
        fill0_next    = fill0_reg;
        fill1_next    = fill1_reg;
        full_cnt_next = full_cnt_reg;
        err_cnt_next  = err_cnt_reg;
        loss_cnt_next = loss_cnt_reg;
        resume_next   = resume_reg;
        epoch_next    = epoch_reg;
        status        = pptb_pkg::ST_OK;
        dump_half     = 1'b0;
        dump_len      = 16'd0;

        unique case (s1_data_reg.operation)
            pptb_pkg::OP_START:
            begin
                status = start_status;
                if (start_go)
                begin
                    active_next  = 1'b0;
                    reason_next  = pptb_pkg::REASON_NONE;
                    running_next = 1'b1;
                end
            end
            pptb_pkg::OP_STOP:
            begin
                running_next = 1'b0;
            end
            pptb_pkg::OP_RESET:
            begin
                running_next = 1'b0;
                ready_next   = 2'b00;
                active_next  = 1'b0;
                fill0_next   = 16'd0;
                fill1_next   = 16'd0;
                reason_next  = pptb_pkg::REASON_NONE;
            end
            pptb_pkg::OP_EVENT:
            begin
                if (running_reg && s1_data_reg.status_pending)
                begin
                    if (s1_data_reg.error_class_set || !s1_data_reg.full_service)
                    begin
                        err_cnt_next = sat_inc(err_cnt_reg);
                        reason_next  = pptb_pkg::REASON_HW;
                        running_next = 1'b0;
                    end
                    else
                    begin
                        // loss is counted even when the offset then fails
                        if (s1_data_reg.loss_flag)
                            loss_cnt_next = sat_inc(loss_cnt_reg);
                        if (!off_ok)
                        begin
                            err_cnt_next = sat_inc(err_cnt_reg);
                            reason_next  = pptb_pkg::REASON_HW;
                            running_next = 1'b0;
                        end
                        else
                        begin
                            if (active_reg)
                                fill1_next = used_sat;
                            else
                                fill0_next = used_sat;
                            ready_next[active_reg] = 1'b1;
                            full_cnt_next = sat_inc(full_cnt_reg);
                            if (other_sealed)
                            begin
                                reason_next  = pptb_pkg::REASON_EXHAUSTED;
                                running_next = 1'b0;
                            end
                            else
                            begin
                                active_next = !active_reg;
                            end
                        end
                    end
                end
            end
            pptb_pkg::OP_SUSP:
            begin
                if (avail_reg && (s1_data_reg.epoch != 64'd0))
                begin
                    resume_next  = running_reg && (ready_reg == 2'b00);
                    epoch_next   = s1_data_reg.epoch;
                    running_next = 1'b0;
                end
            end
            pptb_pkg::OP_RESUME:
            begin
                // status stays ok even when the start is refused
                if (avail_reg && resume_reg && (epoch_reg == s1_data_reg.epoch))
                begin
                    resume_next = 1'b0;
                    if (start_go)
                    begin
                        active_next  = 1'b0;
                        reason_next  = pptb_pkg::REASON_NONE;
                        running_next = 1'b1;
                    end
                end
            end
            pptb_pkg::OP_GUEST:
            begin
                err_cnt_next = sat_inc(err_cnt_reg);
            end
            pptb_pkg::OP_DUMP:
            begin
                if (ready_reg == 2'b00)
                begin
                    status = pptb_pkg::ST_NO_DATA;
                end
                else
                begin
                    dump_half = ready_reg[1];
                    dump_len  = ({16'd0, sel_fill} > DUMP_MAX) ? DUMP_MAX[15:0] : sel_fill;
                end
            end
            default:
            begin
                status = pptb_pkg::ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            avail_reg     <= 1'b0;
            running_reg   <= 1'b0;
            ready_reg     <= 2'b00;
            active_reg    <= 1'b0;
            reason_reg    <= pptb_pkg::REASON_NONE;
            fill0_reg     <= 16'd0;
            fill1_reg     <= 16'd0;
            full_cnt_reg  <= 32'd0;
            err_cnt_reg   <= 32'd0;
            loss_cnt_reg  <= 32'd0;
            resume_reg    <= 1'b0;
            epoch_reg     <= 64'd0;
        end
        else
        begin
            if (cfg_we)
                avail_reg <= cfg_data;

            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s2_load)
                out_valid_reg <= s1_valid_reg;

            if (s1_fire)
            begin
                running_reg  <= running_next;
                ready_reg    <= ready_next;
                active_reg   <= active_next;
                reason_reg   <= reason_next;
                fill0_reg    <= fill0_next;
                fill1_reg    <= fill1_next;
                full_cnt_reg <= full_cnt_next;
                err_cnt_reg  <= err_cnt_next;
                loss_cnt_reg <= loss_cnt_next;
                resume_reg   <= resume_next;
                epoch_reg    <= epoch_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (s1_fire)
        begin
            out_data_reg.is_running    <= running_next;
            out_data_reg.sealed_halves <= ready_next;
            out_data_reg.current_half  <= active_next;
            out_data_reg.stop_reason   <= reason_next;
            out_data_reg.op_status     <= status;
            out_data_reg.full_events   <= full_cnt_next;
            out_data_reg.error_events  <= err_cnt_next;
            out_data_reg.loss_events   <= loss_cnt_next;
            out_data_reg.half0_fill    <= fill0_next;
            out_data_reg.half1_fill    <= fill1_next;
            out_data_reg.dump_half     <= dump_half;
            out_data_reg.dump_length   <= dump_len;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PPTB_ASSERT(a_run_not_on_sealed, running_reg |-> !ready_reg[active_reg],
        "running on a sealed half")
    `PPTB_ASSERT(a_exhausted_both, (reason_reg == pptb_pkg::REASON_EXHAUSTED) |->
        (ready_reg == 2'b11), "exhausted without both halves sealed")
    `PPTB_ASSERT(a_err_cnt_mono, 1'b1 |=> (err_cnt_reg >= $past(err_cnt_reg)),
        "error counter went down")
    `PPTB_ASSERT_ANY(a_stall_needs_beat, in_stall |-> s1_valid_reg,
        "input stalled with empty stage 1")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: ping-pong trace buffer control unit regression
// Directed beats cover the availability register, sealing of both halves,
// exhaustion, bad buffer events, suspend/resume and dump queries. Random
// phases follow, mostly running sessions with valid buffer-full events plus
// noise. Each result beat is checked field by field against a local model
// of the controller, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          BUFFER_BYTES   = 65536;
    localparam int          DUMP_MAX_BYTES = 4096;
    localparam int unsigned HALF_SPAN      = BUFFER_BYTES / 2;

    // buffer event status flags, packed {pending, error_class, full, loss}
    localparam logic [3:0] EV_NONE        = 4'b0000;
    localparam logic [3:0] EV_GOOD        = 4'b1010;
    localparam logic [3:0] EV_GOOD_LOSS   = 4'b1011;
    localparam logic [3:0] EV_NOT_PENDING = 4'b0010;
    localparam logic [3:0] EV_CLASS_ERR   = 4'b1110;
    localparam logic [3:0] EV_NOT_FULL    = 4'b1000;

    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BEATS    = 130;
    localparam int IDLE_LIMIT     = 1000;  // cycles with no beat moving
    localparam int TAIL_CYCLES    = 8;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_data  = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    pptb_pkg::in_beat_t  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pptb_pkg::out_beat_t out_data;

    ping_pong_trace_buffer_control_unit #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .DUMP_MAX_BYTES (DUMP_MAX_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Controller model state: mirrors the unit, advanced once per accepted
    // input beat. The availability bit follows our own register writes.
    // ------------------------------------------------------------------------
    logic        avail_q   = 1'b0;
    logic        running_q = 1'b0;
    logic [1:0]  sealed_q  = 2'b00;
    logic        half_q    = 1'b0;
    logic [1:0]  reason_q  = pptb_pkg::REASON_NONE;
    logic [15:0] fill_q [2] = '{16'd0, 16'd0};
    logic [31:0] full_q    = '0;
    logic [31:0] err_q     = '0;
    logic [31:0] loss_q    = '0;
    logic        resume_q  = 1'b0;
    logic [63:0] epoch_q   = '0;

    pptb_pkg::out_beat_t status_beats_due [$];
    logic [63:0] last_epoch    = 64'd1;
    bit          quiet_tail    = 1'b0;  // no idling in the closing phase
    int          items_sent    = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          idle_cycles     = 0;
    int          stall_left      = 0;

    function automatic logic [31:0] sat_bump(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // start rules, shared by start and a matching resume
    function automatic logic [1:0] attempt_start();
        if (!avail_q)
            return pptb_pkg::ST_NOSUPP;
        if (running_q)
            return pptb_pkg::ST_OK;
        if (sealed_q != 2'b00)
            return pptb_pkg::ST_BUSY;
        half_q    = 1'b0;
        reason_q  = pptb_pkg::REASON_NONE;
        running_q = 1'b1;
        return pptb_pkg::ST_OK;
    endfunction

    function automatic void halt_on_error();
        err_q     = sat_bump(err_q);
        reason_q  = pptb_pkg::REASON_HW;
        running_q = 1'b0;
    endfunction

    // Advance the model by one input beat and return the result beat due.
    function automatic pptb_pkg::out_beat_t compute_status_beat(pptb_pkg::in_beat_t b);
        pptb_pkg::out_beat_t r;
        logic [1:0]  st;
        logic        dh;
        logic [15:0] dl;
        logic [32:0] base;
        logic [32:0] off;
        logic [32:0] used;
        st = pptb_pkg::ST_OK;
        dh = 1'b0;
        dl = 16'd0;
        case (b.operation)
            pptb_pkg::OP_START:
                st = attempt_start();
            pptb_pkg::OP_STOP:
                running_q = 1'b0;
            pptb_pkg::OP_RESET:
            begin
                running_q = 1'b0;
                sealed_q  = 2'b00;
                half_q    = 1'b0;
                fill_q[0] = 16'd0;
                fill_q[1] = 16'd0;
                reason_q  = pptb_pkg::REASON_NONE;
            end
            pptb_pkg::OP_EVENT:
            begin
                if (running_q && b.status_pending)
                begin
                    base = half_q ? 33'(HALF_SPAN) : 33'd0;
                    off  = {1'b0, b.write_offset};
                    if (b.error_class_set || !b.full_service)
                        halt_on_error();
                    else
                    begin
                        // loss is counted even when the offset then fails
                        if (b.loss_flag)
                            loss_q = sat_bump(loss_q);
                        if (off < base || off > base + 33'(HALF_SPAN))
                            halt_on_error();
                        else
                        begin
                            used = off - base;
                            fill_q[half_q] = (used > 33'hFFFF) ? 16'hFFFF : used[15:0];
                            sealed_q[half_q] = 1'b1;
                            full_q = sat_bump(full_q);
                            if (sealed_q[!half_q])
                            begin
                                reason_q  = pptb_pkg::REASON_EXHAUSTED;
                                running_q = 1'b0;
                            end
                            else
                                half_q = !half_q;
                        end
                    end
                end
            end
            pptb_pkg::OP_SUSP:
            begin
                if (avail_q && b.epoch != 64'd0)
                begin
                    resume_q  = running_q && (sealed_q == 2'b00);
                    epoch_q   = b.epoch;
                    running_q = 1'b0;
                end
            end
            pptb_pkg::OP_RESUME:
            begin
                if (avail_q && resume_q && epoch_q == b.epoch)
                begin
                    resume_q = 1'b0;
                    void'(attempt_start());
                end
            end
            pptb_pkg::OP_GUEST:
                err_q = sat_bump(err_q);
            default:
            begin
                if (sealed_q == 2'b00)
                    st = pptb_pkg::ST_NO_DATA;
                else
                begin
                    dh = sealed_q[1];
                    dl = fill_q[dh];
                    if (dl > 16'(DUMP_MAX_BYTES))
                        dl = 16'(DUMP_MAX_BYTES);
                end
            end
        endcase
        r.is_running    = running_q;
        r.sealed_halves = sealed_q;
        r.current_half  = half_q;
        r.stop_reason   = reason_q;
        r.op_status     = st;
        r.full_events   = full_q;
        r.error_events  = err_q;
        r.loss_events   = loss_q;
        r.half0_fill    = fill_q[0];
        r.half1_fill    = fill_q[1];
        r.dump_half     = dh;
        r.dump_length   = dl;
        return r;
    endfunction

    function automatic pptb_pkg::in_beat_t make_beat(logic [2:0] op, logic [3:0] flags,
                                                     logic [31:0] off, logic [63:0] ep);
        pptb_pkg::in_beat_t b;
        b.operation       = op;
        b.status_pending  = flags[3];
        b.error_class_set = flags[2];
        b.full_service    = flags[1];
        b.loss_flag       = flags[0];
        b.write_offset    = off;
        b.epoch           = ep;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Random traffic shaping. Buffer-full events, mostly valid, lead while running,
    // so both halves get sealed and exhaustion is reached often; a stopped
    // unit is usually restarted (after a reset when halves are still sealed).
    // ------------------------------------------------------------------------
    function automatic pptb_pkg::in_beat_t pick_traffic_beat();
        pptb_pkg::in_beat_t b;
        int          roll;
        logic [31:0] base;
        b    = make_beat(pptb_pkg::OP_DUMP, EV_NONE, $urandom, {$urandom, $urandom});
        roll = $urandom_range(0, 99);
        base = half_q ? HALF_SPAN : 32'd0;
        if (!running_q && $urandom_range(0, 2) == 0)
        begin
            b.operation = (sealed_q != 2'b00 && $urandom_range(0, 1) == 1) ?
                          pptb_pkg::OP_RESET : pptb_pkg::OP_START;
        end
        else if (roll < 45)
        begin
            b.operation       = pptb_pkg::OP_EVENT;
            b.status_pending  = 1'b1;
            b.error_class_set = 1'b0;
            b.full_service    = 1'b1;
            b.loss_flag       = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1: b.write_offset = $urandom;                // mostly out of range
                2:    b.write_offset = base + HALF_SPAN + 32'd1;
                3:    b.write_offset = base - 32'd1;            // just below the half
                4:    b.error_class_set = 1'b1;
                5:    b.full_service = 1'b0;
                6:    b.status_pending = 1'b0;
                7:    b.write_offset = base + HALF_SPAN;        // exactly full
                default: b.write_offset = base + $urandom_range(0, HALF_SPAN);
            endcase
        end
        else if (roll < 56)
            b.operation = pptb_pkg::OP_START;
        else if (roll < 63)
            b.operation = pptb_pkg::OP_RESET;
        else if (roll < 67)
            b.operation = pptb_pkg::OP_STOP;
        else if (roll < 75)
            b.operation = pptb_pkg::OP_DUMP;
        else if (roll < 83)
        begin
            b.operation = pptb_pkg::OP_SUSP;
            if ($urandom_range(0, 7) == 0)
                b.epoch = 64'd0;
            last_epoch = b.epoch;
        end
        else if (roll < 91)
        begin
            b.operation = pptb_pkg::OP_RESUME;
            if ($urandom_range(0, 3) != 0)
                b.epoch = last_epoch;
        end
        else if (roll < 95)
            b.operation = pptb_pkg::OP_GUEST;
        else
        begin
            // noise: every field random
            b = make_beat(3'($urandom), 4'($urandom), $urandom, {$urandom, $urandom});
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. One beat per call; the model is advanced at the edge that
    // accepts it. in_valid stays high between back-to-back beats.
    // ------------------------------------------------------------------------
    task automatic send_beat(pptb_pkg::in_beat_t b);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        status_beats_due.push_back(compute_status_beat(b));
        items_sent++;
    endtask

    // Hold the sender until every expected result beat has come back. Every
    // input beat yields exactly one result, so the unit is idle afterwards.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (status_beats_due.size() != 0);
    endtask

    task automatic write_unit_available(logic v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        avail_q  = v;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check against the oldest expectation, and drive random
    // stall bursts (none in the closing phase).
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch: %s at result %0d: got 0x%0h, want 0x%0h",
                 field, results_checked, got, want);
    endtask

    always @(posedge clk)
    begin
        pptb_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_beats_due.size() == 0)
                report_mismatch("result beat with nothing due", 64'd0, 64'd0);
            else
            begin
                want = status_beats_due.pop_front();
                if (out_data.is_running !== want.is_running)
                    report_mismatch("is_running", 64'(out_data.is_running),
                                    64'(want.is_running));
                if (out_data.sealed_halves !== want.sealed_halves)
                    report_mismatch("sealed_halves", 64'(out_data.sealed_halves),
                                    64'(want.sealed_halves));
                if (out_data.current_half !== want.current_half)
                    report_mismatch("current_half", 64'(out_data.current_half),
                                    64'(want.current_half));
                if (out_data.stop_reason !== want.stop_reason)
                    report_mismatch("stop_reason", 64'(out_data.stop_reason),
                                    64'(want.stop_reason));
                if (out_data.op_status !== want.op_status)
                    report_mismatch("op_status", 64'(out_data.op_status),
                                    64'(want.op_status));
                if (out_data.full_events !== want.full_events)
                    report_mismatch("full_events", 64'(out_data.full_events),
                                    64'(want.full_events));
                if (out_data.error_events !== want.error_events)
                    report_mismatch("error_events", 64'(out_data.error_events),
                                    64'(want.error_events));
                if (out_data.loss_events !== want.loss_events)
                    report_mismatch("loss_events", 64'(out_data.loss_events),
                                    64'(want.loss_events));
                if (out_data.half0_fill !== want.half0_fill)
                    report_mismatch("half0_fill", 64'(out_data.half0_fill),
                                    64'(want.half0_fill));
                if (out_data.half1_fill !== want.half1_fill)
                    report_mismatch("half1_fill", 64'(out_data.half1_fill),
                                    64'(want.half1_fill));
                if (out_data.dump_half !== want.dump_half)
                    report_mismatch("dump_half", 64'(out_data.dump_half),
                                    64'(want.dump_half));
                if (out_data.dump_length !== want.dump_length)
                    report_mismatch("dump_length", 64'(out_data.dump_length),
                                    64'(want.dump_length));
            end
            results_checked++;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 3) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: a correct run never goes this long without a beat or a write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: %0d results still due", status_beats_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // unit not available: start refused, suspend ignored, no dump data
    task automatic test_unavailable_unit();
        write_unit_available(1'b0);
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_SUSP, EV_NONE, 32'd0, 64'd1));
        send_beat(make_beat(pptb_pkg::OP_DUMP, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_GUEST, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_STOP, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_RESET, EV_NONE, 32'd0, 64'd0));
        wait_for_results();
    endtask

    // both halves filled to the brim, exhaustion, dumps, start while sealed
    task automatic test_seal_and_exhaust();
        write_unit_available(1'b1);
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        // already running
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_GOOD_LOSS, HALF_SPAN, 64'd0));
        // half 0, clipped
        send_beat(make_beat(pptb_pkg::OP_DUMP, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_GOOD, 2 * HALF_SPAN, 64'd0));
        // half 1
        send_beat(make_beat(pptb_pkg::OP_DUMP, EV_NONE, 32'd0, 64'd0));
        // busy
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_RESET, EV_NONE, 32'hFFFF_FFFF, '1));
    endtask

    // ignored event, empty seal, offset below the half, bad status bits
    task automatic test_bad_events();
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_NOT_PENDING, 32'd16, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_GOOD, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_GOOD, HALF_SPAN - 1, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_RESET, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_CLASS_ERR, 32'd8, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_EVENT, EV_NOT_FULL, 32'd8, 64'd0));
    endtask

    // suspend while running and empty arms a resume; epoch must match
    task automatic test_suspend_resume();
        send_beat(make_beat(pptb_pkg::OP_START, EV_NONE, 32'd0, 64'd0));
        send_beat(make_beat(pptb_pkg::OP_SUSP, EV_NONE, 32'd0, '1));
        send_beat(make_beat(pptb_pkg::OP_RESUME, EV_NONE, 32'd0, 64'd1));
        send_beat(make_beat(pptb_pkg::OP_RESUME, EV_NONE, 32'd0, '1));
        // zero epoch
        send_beat(make_beat(pptb_pkg::OP_SUSP, EV_NONE, 32'd0, 64'd0));
        wait_for_results();
    endtask

    // dropping availability leaves a running unit running
    task automatic test_availability_drop();
        write_unit_available(1'b0);
        send_beat(make_beat(pptb_pkg::OP_GUEST, EV_NONE, 32'd0, 64'd0));
        wait_for_results();
        write_unit_available(1'b1);
    endtask

    // random phases at several register settings, last phase without idling
    task automatic test_random_traffic();
        int  phase;
        int  k;
        logic avail;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            if (phase == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            if (phase == 0)
                avail = 1'b1;
            else if (phase == 1)
                avail = 1'b0;
            else
                avail = ($urandom_range(0, 4) != 0);
            write_unit_available(avail);
            for (k = 0; k < PHASE_BEATS; k++)
            begin
                // occasional full drain mid-phase
                if (!quiet_tail && $urandom_range(0, 99) == 0)
                    wait_for_results();
                send_beat(pick_traffic_beat());
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unavailable_unit();
        test_seal_and_exhaust();
        test_bad_events();
        test_suspend_resume();
        test_availability_drop();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d input beats, checked %0d result beats, %0d mismatches.",
                 items_sent, results_checked, mismatch_count);
        $display("Model totals: %0d halves sealed, %0d errors, %0d loss events.",
                 full_q, err_q, loss_q);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
